### rtl/core/wat_pkg.sv
// shared types, codes and constants of the wind angle trimmed mean filter
package wat_pkg;

  localparam int SAMPLE_W   = 9;
  localparam int BAND_W     = 8;
  localparam int STATUS_W   = 2;
  localparam int CFG_ADDR_W = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [BAND_W-1:0]          band_t;
  typedef logic [STATUS_W-1:0]        status_t;
  typedef logic [CFG_ADDR_W-1:0]      cfg_addr_t;

  // result status codes
  localparam status_t ST_VALID    = 2'd0;
  localparam status_t ST_NOT_FULL = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;

  // register indexes
  localparam cfg_addr_t REG_WIDE_BAND   = 2'd0;
  localparam cfg_addr_t REG_NARROW_BAND = 2'd1;
  localparam cfg_addr_t REG_TIE_ANGLE   = 2'd2;

  // register reset values
  localparam band_t WIDE_BAND_RST   = 8'd130;
  localparam band_t NARROW_BAND_RST = 8'd50;
  localparam band_t TIE_ANGLE_RST   = 8'd90;

  // reference angle of the tie break
  localparam logic signed [10:0] TIE_REF = 11'sd180;

  typedef struct packed {
    logic load;
    logic scan_max;
    logic scan_min;
    logic scan_acc;
    logic div_init;
    logic div_step;
    logic finish;
  } wat_cmd_t;

  typedef struct packed {
    logic will_fill;
    logic idx_last;
    logic div_last;
  } wat_sts_t;

endpackage

### rtl/core/wat_if.sv
// request channel interfaces: sample input, result output, register writes
interface wat_in_if;
  import wat_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface wat_out_if;
  import wat_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  sample_t mean;
  modport source (output valid, output status, output mean, input ready);
  modport sink (input valid, input status, input mean, output ready);
endinterface

interface wat_cfg_if;
  import wat_pkg::*;
  logic      valid;
  logic      ready;
  cfg_addr_t addr;
  band_t     data;
  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

### rtl/core/wat_dp.sv
// datapath: sample window, extreme scans, band accumulation and serial divider
module wat_dp #(
  parameter int WINDOW = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  wat_pkg::wat_cmd_t cmd,
  input  wat_pkg::sample_t  sample,
  input  wat_pkg::band_t    wide_band,
  input  wat_pkg::band_t    narrow_band,
  input  wat_pkg::band_t    tie_angle,
  output wat_pkg::wat_sts_t sts,
  output wat_pkg::status_t  res_status,
  output wat_pkg::sample_t  res_mean
);
  import wat_pkg::*;

  localparam int IDX_W  = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int CNT_W  = $clog2(WINDOW);
  localparam int TERM_W = BAND_W + 2;
  localparam int SUM_W  = TERM_W + CNT_W;
  localparam int PSUM_W = SAMPLE_W + CNT_W;
  localparam int DCNT_W = $clog2(SUM_W);
  localparam int KEEP_N = WINDOW - 2;

  sample_t                  win_r [WINDOW];
  logic [FILL_W-1:0]        fill_r;
  logic [IDX_W-1:0]         idx_r;
  sample_t                  maxv_r, minv_r, lastk_r;
  logic [IDX_W-1:0]         imax_r, imin_r;
  logic                     minok_r;
  logic                     negf_r, posf_r;
  logic [CNT_W-1:0]         c1_r, c2_r;
  logic [SUM_W-1:0]         sumw_r, sumn_r;
  logic signed [PSUM_W-1:0] sump_r;
  logic [SUM_W-1:0]         quo_r;
  logic [CNT_W-1:0]         rem_r, dvs_r;
  logic [DCNT_W-1:0]        dcnt_r;
  band_t                    band_r;
  logic                     mixed_r, neg_r, empty_r;
  status_t                  status_r;
  sample_t                  mean_r;

  sample_t                  cur;
  logic                     first, scan, kept;
  logic                     max_upd, min_upd;
  logic signed [TERM_W-1:0] vx, wbx, nbx;
  logic                     in_w, in_n;
  logic [TERM_W-1:0]        termw, termn;
  logic                     negf_nxt, posf_nxt;
  logic [CNT_W-1:0]         c1_nxt, c2_nxt;
  logic [SUM_W-1:0]         sumw_nxt, sumn_nxt;
  logic signed [PSUM_W-1:0] sump_nxt;
  logic signed [10:0]       tie_lhs;
  logic                     mixed, use_n;
  logic signed [PSUM_W-1:0] psum_mag;
  logic [SUM_W-1:0]         dvd_nxt;
  logic [CNT_W-1:0]         dvs_nxt;
  logic [CNT_W:0]           rem_sh;
  logic                     ge;
  logic [CNT_W-1:0]         rem_nxt;
  logic signed [SUM_W:0]    qx, banded, plain;

  assign cur   = win_r[idx_r];
  assign first = (idx_r == '0);
  assign scan  = cmd.scan_max | cmd.scan_min | cmd.scan_acc;
  assign kept  = (idx_r != imax_r) && (idx_r != imin_r);

  assign sts.will_fill = (fill_r >= FILL_W'(WINDOW - 1));
  assign sts.idx_last  = (idx_r == IDX_W'(WINDOW - 1));
  assign sts.div_last  = (dcnt_r == DCNT_W'(SUM_W - 1));

  // window shift, oldest entry first
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WINDOW-1] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      idx_r  <= '0;
    end else begin
      if (cmd.load && fill_r != FILL_W'(WINDOW)) begin
        fill_r <= fill_r + 1'b1;
      end
      if (cmd.load) begin
        idx_r <= '0;
      end else if (scan) begin
        idx_r <= sts.idx_last ? '0 : idx_r + 1'b1;
      end
    end
  end

  // newest maximum, then newest minimum among the rest
  assign max_upd = first || (cur >= maxv_r);
  assign min_upd = (idx_r != imax_r) && (!(minok_r && !first) || (cur <= minv_r));

  always_ff @(posedge clk) begin
    if (cmd.scan_max && max_upd) begin
      maxv_r <= cur;
      imax_r <= idx_r;
    end
    if (cmd.scan_min) begin
      if (min_upd) begin
        minv_r  <= cur;
        imin_r  <= idx_r;
        minok_r <= 1'b1;
      end else if (first) begin
        minok_r <= 1'b0;
      end
    end
  end

  // band tests and accumulation over the kept samples
  always_comb begin
    vx    = {cur[SAMPLE_W-1], cur};
    wbx   = $signed({2'b00, wide_band});
    nbx   = $signed({2'b00, narrow_band});
    in_w  = kept && (vx >= -wbx) && (vx <= wbx);
    in_n  = kept && (vx >= -nbx) && (vx <= nbx);
    termw = TERM_W'(vx + wbx);
    termn = TERM_W'(vx + nbx);

    negf_nxt = (first ? 1'b0 : negf_r) | (kept && (cur < 0));
    posf_nxt = (first ? 1'b0 : posf_r) | (kept && (cur > 0));
    c1_nxt   = (first ? '0 : c1_r) + CNT_W'(in_w);
    c2_nxt   = (first ? '0 : c2_r) + CNT_W'(in_n);
    sumw_nxt = (first ? '0 : sumw_r) + (in_w ? {{CNT_W{1'b0}}, termw} : '0);
    sumn_nxt = (first ? '0 : sumn_r) + (in_n ? {{CNT_W{1'b0}}, termn} : '0);
    sump_nxt = (first ? '0 : sump_r)
             + (kept ? {{CNT_W{cur[SAMPLE_W-1]}}, cur} : '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_acc) begin
      negf_r <= negf_nxt;
      posf_r <= posf_nxt;
      c1_r   <= c1_nxt;
      c2_r   <= c2_nxt;
      sumw_r <= sumw_nxt;
      sumn_r <= sumn_nxt;
      sump_r <= sump_nxt;
      if (kept) begin
        lastk_r <= cur;
      end
    end
  end

  // band choice and divider operands
  always_comb begin
    mixed    = negf_r & posf_r;
    tie_lhs  = TIE_REF - {{2{lastk_r[SAMPLE_W-1]}}, lastk_r};
    use_n    = (c1_r != c2_r) ? (c2_r > c1_r) : (tie_lhs > $signed({3'b000, tie_angle}));
    psum_mag = sump_r[PSUM_W-1] ? -sump_r : sump_r;
    if (mixed) begin
      dvd_nxt = use_n ? sumn_r : sumw_r;
      dvs_nxt = use_n ? c2_r : c1_r;
    end else begin
      dvd_nxt = {{(SUM_W-PSUM_W){1'b0}}, psum_mag};
      dvs_nxt = CNT_W'(KEEP_N);
    end
  end

  // restoring divider, one quotient bit a cycle
  always_comb begin
    rem_sh  = {rem_r, quo_r[SUM_W-1]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = ge ? CNT_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo_r   <= dvd_nxt;
      rem_r   <= '0;
      dvs_r   <= dvs_nxt;
      dcnt_r  <= '0;
      band_r  <= use_n ? narrow_band : wide_band;
      mixed_r <= mixed;
      neg_r   <= sump_r[PSUM_W-1];
      empty_r <= mixed && (dvs_nxt == '0);
    end else if (cmd.div_step) begin
      quo_r  <= {quo_r[SUM_W-2:0], ge};
      rem_r  <= rem_nxt;
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  // final correction of the quotient
  always_comb begin
    qx     = $signed({1'b0, quo_r});
    banded = qx - $signed({{(SUM_W-BAND_W+1){1'b0}}, band_r});
    plain  = neg_r ? -qx : qx;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r <= ST_NOT_FULL;
      mean_r   <= '0;
    end else if (cmd.finish) begin
      if (mixed_r && empty_r) begin
        status_r <= ST_EMPTY;
        mean_r   <= '0;
      end else begin
        status_r <= ST_VALID;
        mean_r   <= mixed_r ? banded[SAMPLE_W-1:0] : plain[SAMPLE_W-1:0];
      end
    end
  end

  assign res_status = status_r;
  assign res_mean   = mean_r;

endmodule

### rtl/core/wat_ctrl.sv
// controller state machine sequencing scans, division and result hand-off
module wat_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_free,
  input  wat_pkg::wat_sts_t sts,
  output wat_pkg::wat_cmd_t cmd,
  output logic              in_ready,
  output logic              emit
);
  import wat_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAX  = 3'd1;
  localparam logic [2:0] S_MIN  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_PREP = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    emit      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.will_fill ? S_MAX : S_DONE;
        end
      end
      S_MAX: begin
        cmd.scan_max = 1'b1;
        if (sts.idx_last) state_nxt = S_MIN;
      end
      S_MIN: begin
        cmd.scan_min = 1'b1;
        if (sts.idx_last) state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.scan_acc = 1'b1;
        if (sts.idx_last) state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/wind_angle_trimmed_mean_top.sv
// top level of the wind angle trimmed mean filter
// Each sample request on in_ch is shifted into a window of the WINDOW newest
// wind angles and gives exactly one result request on out_ch. Until the
// window has filled, the result carries status 1 (not full) and mean 0.
// Once full, the newest maximum and then the newest minimum are dropped; if
// the kept samples have both signs the mean of the wide or narrow band
// (offset by the band value) is given, otherwise the plain mean truncated
// toward zero, and status 2 marks an empty band. A full window is worked in
// three passes over the window at one entry a cycle (maximum, minimum, band
// sums) and a restoring divider giving one quotient bit a cycle. One sample
// is in work at a time; the result waits in an output register, so the next
// sample is taken while the previous result is still held. Registers are
// written through cfg_ch (always ready); the user must write them only
// while idle, as the block itself does not enforce it.
module wind_angle_trimmed_mean_top #(
  parameter int WINDOW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  wat_in_if.sink        in_ch,
  wat_out_if.source     out_ch,
  wat_cfg_if.sink       cfg_ch
);
  import wat_pkg::*;

  // configuration registers
  band_t wide_band_r, narrow_band_r, tie_angle_r;

  // output register
  logic    out_valid_r;
  status_t out_status_r;
  sample_t out_mean_r;

  wat_cmd_t cmd;
  wat_sts_t sts;
  logic     emit;
  logic     out_free;
  status_t  res_status;
  sample_t  res_mean;

  assign cfg_ch.ready = 1'b1;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_band_r   <= WIDE_BAND_RST;
      narrow_band_r <= NARROW_BAND_RST;
      tie_angle_r   <= TIE_ANGLE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        REG_WIDE_BAND:   wide_band_r   <= cfg_ch.data;
        REG_NARROW_BAND: narrow_band_r <= cfg_ch.data;
        REG_TIE_ANGLE:   tie_angle_r   <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  // output slot free when empty or draining this cycle
  assign out_free = !out_valid_r || out_ch.ready;

  wat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ch.ready),
    .emit     (emit)
  );

  wat_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sample      (in_ch.sample),
    .wide_band   (wide_band_r),
    .narrow_band (narrow_band_r),
    .tie_angle   (tie_angle_r),
    .sts         (sts),
    .res_status  (res_status),
    .res_mean    (res_mean)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded with the request
  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= res_status;
      out_mean_r   <= res_mean;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.mean   = out_mean_r;

endmodule

### rtl/core/wat_chk.sv
// port-level checker of the wind angle trimmed mean filter and its bind
module wat_chk (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input wat_pkg::status_t out_status,
  input wat_pkg::sample_t out_mean
);
  import wat_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_mean))
    else $error("result changed while stalled");

  // mean is zero unless the status reports a valid mean
  a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_VALID) |-> (out_mean == '0))
    else $error("non-zero mean with error status");

  // one sample in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while previous one in work");

  // no result can appear in the cycle straight after a sample request
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result raised too early");

endmodule

bind wind_angle_trimmed_mean_top wat_chk u_wat_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_mean   (out_ch.mean)
);
